FILE: sv/assert_macros.svh
// Assertion macros for the tracker RTL, used by dalt_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that b holds in the same cycle as a.
`define ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Checks that b holds in the cycle after a.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: sv/dalt_pkg.sv
// Types, constants and helper functions for the dual-axis light tracker.
`timescale 1ns / 1ps

package dalt_pkg;

  localparam int TOL_BITS = 10;
  localparam int POS_BITS = 8;
  localparam int QTR_BITS = 10;
  localparam int CNT_BITS = 8;
  localparam int IDX_BITS = 3;
  localparam int CFG_BITS = 10;

  typedef enum logic [IDX_BITS-1:0] {
    REG_TOL_MIN  = 3'd0,
    REG_TOL_MAX  = 3'd1,
    REG_VERT_MIN = 3'd2,
    REG_VERT_MAX = 3'd3,
    REG_HOR_MIN  = 3'd4,
    REG_HOR_MAX  = 3'd5,
    REG_REFRESH  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [TOL_BITS-1:0] tol_min;
    logic [TOL_BITS-1:0] tol_max;
    logic [POS_BITS-1:0] vert_min;
    logic [POS_BITS-1:0] vert_max;
    logic [POS_BITS-1:0] hor_min;
    logic [POS_BITS-1:0] hor_max;
    logic [CNT_BITS-1:0] refresh_period;
  } cfg_t;

  localparam logic [TOL_BITS-1:0] TOL_MIN_RST  = 10'd30;
  localparam logic [TOL_BITS-1:0] TOL_MAX_RST  = 10'd250;
  localparam logic [POS_BITS-1:0] VERT_MIN_RST = 8'd0;
  localparam logic [POS_BITS-1:0] VERT_MAX_RST = 8'd50;
  localparam logic [POS_BITS-1:0] HOR_MIN_RST  = 8'd0;
  localparam logic [POS_BITS-1:0] HOR_MAX_RST  = 8'd100;
  localparam logic [CNT_BITS-1:0] REFRESH_RST  = 8'd201;
  localparam logic [QTR_BITS-1:0] QTR_RST      = 10'd200;
  localparam logic [TOL_BITS-1:0] TOL_RST      = 10'd100;

  // One quarter-degree step with the clamp. The limit checks are written as
  // compares on the old position so no signed arithmetic is needed.
  function automatic logic [QTR_BITS-1:0] step_axis(
    input logic [QTR_BITS-1:0] q,
    input logic                up,
    input logic [POS_BITS-1:0] lo,
    input logic [POS_BITS-1:0] hi
  );
    logic [QTR_BITS-1:0] qlo;
    logic [QTR_BITS-1:0] qhi;
    qlo = {lo, 2'b00};
    qhi = {hi, 2'b00};
    if (up) begin
      step_axis = (q >= qhi) ? qhi : q + 10'd1;
    end else begin
      step_axis = (q <= qlo) ? qlo : q - 10'd1;
    end
  endfunction

  // Rounds a quarter-degree position half up to whole degrees.
  function automatic logic [POS_BITS-1:0] round_deg(input logic [QTR_BITS-1:0] q);
    logic [QTR_BITS:0] sum;
    sum = {1'b0, q} + 11'd2;
    round_deg = sum[QTR_BITS-1:2];
  endfunction

endpackage

FILE: sv/dual_axis_light_tracker_stepper_unit.sv
// Top level of the dual-axis light tracker stepper.
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid / in_ready): one request carries four light
// samples and one knob sample. Result channel (out_valid / out_ready): one
// result per request with both axis positions in whole degrees, the two
// servo command flags and the tolerance in effect after the request.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; write only while no request is in flight.
// A request waits in the input register until the result register is empty
// or being taken, then moves into the result register and raises out_valid.
// Throughput: one request per cycle while out_ready stays high. The position,
// tolerance and refresh counter update as each request leaves the input
// register.
// Reset (rst_n low, synchronous) restores the register defaults, both
// positions to 50 degrees, the tolerance to 100 and empties both stages.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; in_ready then drops until the
// result is taken.

module dual_axis_light_tracker_stepper_unit #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SAMPLE_BITS-1:0]            in_right_bottom,
  input  logic [SAMPLE_BITS-1:0]            in_left_bottom,
  input  logic [SAMPLE_BITS-1:0]            in_right_top,
  input  logic [SAMPLE_BITS-1:0]            in_left_top,
  input  logic [SAMPLE_BITS-1:0]            in_knob,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dalt_pkg::POS_BITS-1:0]     out_vertical_degrees,
  output logic                              out_vertical_command,
  output logic [dalt_pkg::POS_BITS-1:0]     out_horizontal_degrees,
  output logic                              out_horizontal_command,
  output logic [dalt_pkg::TOL_BITS-1:0]     out_tolerance_now,
  input  logic                              cfg_we,
  input  logic [dalt_pkg::IDX_BITS-1:0]     cfg_index,
  input  logic [dalt_pkg::CFG_BITS-1:0]     cfg_data
);

  localparam int PW = SAMPLE_BITS + dalt_pkg::TOL_BITS;

  dalt_pkg::cfg_t         cfg;
  logic                   s1_valid, s1_take;
  logic [SAMPLE_BITS-1:0] s1_rb, s1_lb, s1_rt, s1_lt;
  logic [PW-1:0]          s1_prod;

  dalt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dalt_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_right_bottom (in_right_bottom),
    .in_left_bottom  (in_left_bottom),
    .in_right_top    (in_right_top),
    .in_left_top     (in_left_top),
    .in_knob         (in_knob),
    .cfg             (cfg),
    .s1_take         (s1_take),
    .s1_valid        (s1_valid),
    .s1_rb           (s1_rb),
    .s1_lb           (s1_lb),
    .s1_rt           (s1_rt),
    .s1_lt           (s1_lt),
    .s1_prod         (s1_prod)
  );

  dalt_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg),
    .s1_valid               (s1_valid),
    .s1_take                (s1_take),
    .s1_rb                  (s1_rb),
    .s1_lb                  (s1_lb),
    .s1_rt                  (s1_rt),
    .s1_lt                  (s1_lt),
    .s1_prod                (s1_prod),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_vertical_degrees   (out_vertical_degrees),
    .out_vertical_command   (out_vertical_command),
    .out_horizontal_degrees (out_horizontal_degrees),
    .out_horizontal_command (out_horizontal_command),
    .out_tolerance_now      (out_tolerance_now)
  );

endmodule

FILE: sv/dalt_cfg_regs.sv
// Configuration register file for the light tracker.
`timescale 1ns / 1ps

module dalt_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dalt_pkg::IDX_BITS-1:0]       cfg_index,
  input  logic [dalt_pkg::CFG_BITS-1:0]       cfg_data,
  output dalt_pkg::cfg_t                      cfg
);

  dalt_pkg::cfg_t cfg_r;
  dalt_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (dalt_pkg::cfg_idx_t'(cfg_index))
        dalt_pkg::REG_TOL_MIN:  cfg_nxt.tol_min        = cfg_data[dalt_pkg::TOL_BITS-1:0];
        dalt_pkg::REG_TOL_MAX:  cfg_nxt.tol_max        = cfg_data[dalt_pkg::TOL_BITS-1:0];
        dalt_pkg::REG_VERT_MIN: cfg_nxt.vert_min       = cfg_data[dalt_pkg::POS_BITS-1:0];
        dalt_pkg::REG_VERT_MAX: cfg_nxt.vert_max       = cfg_data[dalt_pkg::POS_BITS-1:0];
        dalt_pkg::REG_HOR_MIN:  cfg_nxt.hor_min        = cfg_data[dalt_pkg::POS_BITS-1:0];
        dalt_pkg::REG_HOR_MAX:  cfg_nxt.hor_max        = cfg_data[dalt_pkg::POS_BITS-1:0];
        dalt_pkg::REG_REFRESH:  cfg_nxt.refresh_period = cfg_data[dalt_pkg::CNT_BITS-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tol_min        <= dalt_pkg::TOL_MIN_RST;
      cfg_r.tol_max        <= dalt_pkg::TOL_MAX_RST;
      cfg_r.vert_min       <= dalt_pkg::VERT_MIN_RST;
      cfg_r.vert_max       <= dalt_pkg::VERT_MAX_RST;
      cfg_r.hor_min        <= dalt_pkg::HOR_MIN_RST;
      cfg_r.hor_max        <= dalt_pkg::HOR_MAX_RST;
      cfg_r.refresh_period <= dalt_pkg::REFRESH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/dalt_front.sv
// Input register stage: captures the samples and the knob-times-span product.
`timescale 1ns / 1ps

module dalt_front #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             in_right_bottom,
  input  logic [SAMPLE_BITS-1:0]             in_left_bottom,
  input  logic [SAMPLE_BITS-1:0]             in_right_top,
  input  logic [SAMPLE_BITS-1:0]             in_left_top,
  input  logic [SAMPLE_BITS-1:0]             in_knob,
  input  dalt_pkg::cfg_t                     cfg,
  input  logic                               s1_take,
  output logic                               s1_valid,
  output logic [SAMPLE_BITS-1:0]             s1_rb,
  output logic [SAMPLE_BITS-1:0]             s1_lb,
  output logic [SAMPLE_BITS-1:0]             s1_rt,
  output logic [SAMPLE_BITS-1:0]             s1_lt,
  output logic [SAMPLE_BITS+dalt_pkg::TOL_BITS-1:0] s1_prod
);

  localparam int PW = SAMPLE_BITS + dalt_pkg::TOL_BITS;

  logic                    valid_r;
  logic                    valid_nxt;
  logic [SAMPLE_BITS-1:0]  rb_r, lb_r, rt_r, lt_r;
  logic [PW-1:0]           prod_r;
  logic [dalt_pkg::TOL_BITS-1:0] span;
  logic [PW-1:0]           prod_nxt;
  logic                    load;

  // A reversed tolerance range collapses to a zero span.
  assign span = (cfg.tol_max >= cfg.tol_min) ? (cfg.tol_max - cfg.tol_min)
                                             : '0;
  assign prod_nxt = PW'(in_knob) * PW'(span);

  assign in_ready  = !valid_r || s1_take;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (s1_take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rb_r   <= in_right_bottom;
      lb_r   <= in_left_bottom;
      rt_r   <= in_right_top;
      lt_r   <= in_left_top;
      prod_r <= prod_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_rb    = rb_r;
  assign s1_lb    = lb_r;
  assign s1_rt    = rt_r;
  assign s1_lt    = lt_r;
  assign s1_prod  = prod_r;

endmodule

FILE: sv/dalt_core.sv
// Tracking step: axis tests, position and tolerance state, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dalt_core #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dalt_pkg::cfg_t                     cfg,
  input  logic                               s1_valid,
  output logic                               s1_take,
  input  logic [SAMPLE_BITS-1:0]             s1_rb,
  input  logic [SAMPLE_BITS-1:0]             s1_lb,
  input  logic [SAMPLE_BITS-1:0]             s1_rt,
  input  logic [SAMPLE_BITS-1:0]             s1_lt,
  input  logic [SAMPLE_BITS+dalt_pkg::TOL_BITS-1:0] s1_prod,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dalt_pkg::POS_BITS-1:0]      out_vertical_degrees,
  output logic                               out_vertical_command,
  output logic [dalt_pkg::POS_BITS-1:0]      out_horizontal_degrees,
  output logic                               out_horizontal_command,
  output logic [dalt_pkg::TOL_BITS-1:0]      out_tolerance_now
);

  localparam int PW = SAMPLE_BITS + dalt_pkg::TOL_BITS;
  localparam int ZW = PW + 1;
  localparam int CW = (SAMPLE_BITS > dalt_pkg::TOL_BITS) ? SAMPLE_BITS : dalt_pkg::TOL_BITS;
  localparam logic [ZW-1:0] FULL = ZW'((1 << SAMPLE_BITS) - 1);
  localparam logic [ZW-1:0] HALF = ZW'((1 << (SAMPLE_BITS - 1)) - 1);

  logic [dalt_pkg::QTR_BITS-1:0] vq_r, vq_nxt, hq_r, hq_nxt;
  logic [dalt_pkg::TOL_BITS-1:0] tol_r, tol_nxt;
  logic [dalt_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                          ov_r, ov_nxt;
  logic [dalt_pkg::POS_BITS-1:0] vdeg_r, hdeg_r;
  logic                          vcmd_r, hcmd_r;
  logic [dalt_pkg::TOL_BITS-1:0] otol_r;

  logic [SAMPLE_BITS:0]   sum_top, sum_bot, sum_left, sum_right;
  logic [SAMPLE_BITS-1:0] top, bottom, left, right, adv, adh;
  logic                   vcmd, hcmd, reload;
  logic [ZW-1:0]          z, q0, r, q1, r2, add;
  logic [dalt_pkg::TOL_BITS-1:0] tol_new;

  assign s1_take = s1_valid && (!ov_r || out_ready);

  // Pair averages with floor halving.
  assign sum_top   = {1'b0, s1_lt} + {1'b0, s1_rt};
  assign sum_bot   = {1'b0, s1_lb} + {1'b0, s1_rb};
  assign sum_left  = {1'b0, s1_lb} + {1'b0, s1_lt};
  assign sum_right = {1'b0, s1_rb} + {1'b0, s1_rt};
  assign top    = sum_top[SAMPLE_BITS:1];
  assign bottom = sum_bot[SAMPLE_BITS:1];
  assign left   = sum_left[SAMPLE_BITS:1];
  assign right  = sum_right[SAMPLE_BITS:1];

  assign adv = (top >= bottom) ? top - bottom : bottom - top;
  assign adh = (left >= right) ? left - right : right - left;
  assign vcmd = CW'(adv) > CW'(tol_r);
  assign hcmd = CW'(adh) > CW'(tol_r);

  // Rounded knob scaling: floor((prod + HALF) / FULL) with FULL = 2^N - 1.
  // Two end-around folds leave a remainder below twice FULL, so one compare
  // finishes the quotient.
  assign z   = ZW'(s1_prod) + HALF;
  assign q0  = z >> SAMPLE_BITS;
  assign r   = (z & FULL) + q0;
  assign q1  = r >> SAMPLE_BITS;
  assign r2  = (r & FULL) + q1;
  assign add = q0 + q1 + ((r2 >= FULL) ? ZW'(1) : ZW'(0));
  assign tol_new = cfg.tol_min + add[dalt_pkg::TOL_BITS-1:0];

  assign cnt_inc = cnt_r + 8'd1;
  assign reload  = cnt_inc >= cfg.refresh_period;

  always_comb begin
    vq_nxt  = vq_r;
    hq_nxt  = hq_r;
    tol_nxt = tol_r;
    cnt_nxt = cnt_r;
    if (s1_take) begin
      // A passing axis test implies a nonzero difference, so the direction
      // is always defined when the axis moves.
      if (vcmd) begin
        vq_nxt = dalt_pkg::step_axis(vq_r, top < bottom, cfg.vert_min, cfg.vert_max);
      end
      if (hcmd) begin
        hq_nxt = dalt_pkg::step_axis(hq_r, left < right, cfg.hor_min, cfg.hor_max);
      end
      if (reload) begin
        tol_nxt = tol_new;
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  assign ov_nxt = s1_take ? 1'b1 : ((ov_r && out_ready) ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r  <= dalt_pkg::QTR_RST;
      hq_r  <= dalt_pkg::QTR_RST;
      tol_r <= dalt_pkg::TOL_RST;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      vq_r  <= vq_nxt;
      hq_r  <= hq_nxt;
      tol_r <= tol_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      vdeg_r <= dalt_pkg::round_deg(vq_nxt);
      hdeg_r <= dalt_pkg::round_deg(hq_nxt);
      vcmd_r <= vcmd;
      hcmd_r <= hcmd;
      otol_r <= tol_nxt;
    end
  end

  assign out_valid              = ov_r;
  assign out_vertical_degrees   = vdeg_r;
  assign out_vertical_command   = vcmd_r;
  assign out_horizontal_degrees = hdeg_r;
  assign out_horizontal_command = hcmd_r;
  assign out_tolerance_now      = otol_r;

  `ASSERT_NEXT(a_vert_holds, clk, rst_n, !(s1_take && vcmd), $stable(vq_r))
  `ASSERT_NEXT(a_hor_holds, clk, rst_n, !(s1_take && hcmd), $stable(hq_r))
  `ASSERT_NEXT(a_tol_holds, clk, rst_n, !(s1_take && reload), $stable(tol_r))
  `ASSERT_NEXT(a_reload_clears, clk, rst_n, s1_take && reload, cnt_r == '0)
  `ASSERT_NOW(a_take_fills_out, clk, rst_n, s1_take, ov_nxt)

endmodule

FILE: tb/tb_top.sv
// Testbench for the tracker stepper: directed and random requests checked against a step model.
`timescale 1ns / 1ps

module tb_top;
  import dalt_pkg::*;

  localparam int SB          = 10;
  localparam int SETTLE      = 4;
  localparam int QUIET_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SB-1:0]       in_right_bottom = '0;
  logic [SB-1:0]       in_left_bottom = '0;
  logic [SB-1:0]       in_right_top = '0;
  logic [SB-1:0]       in_left_top = '0;
  logic [SB-1:0]       in_knob = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [POS_BITS-1:0] out_vertical_degrees;
  logic                out_vertical_command;
  logic [POS_BITS-1:0] out_horizontal_degrees;
  logic                out_horizontal_command;
  logic [TOL_BITS-1:0] out_tolerance_now;
  logic                cfg_we = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = REG_TOL_MIN;
  logic [CFG_BITS-1:0] cfg_data = '0;

  typedef struct packed {
    logic [POS_BITS-1:0] v_deg;
    logic                v_cmd;
    logic [POS_BITS-1:0] h_deg;
    logic                h_cmd;
    logic [TOL_BITS-1:0] tol;
  } aim_t;

  aim_t                aim_queue[$];
  cfg_t                regs;
  logic [QTR_BITS-1:0] v_qtr;
  logic [QTR_BITS-1:0] h_qtr;
  logic [TOL_BITS-1:0] tol_cur;
  logic [CNT_BITS-1:0] refresh_cnt;
  int                  fault_count = 0;
  int                  quiet_cycles = 0;
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  sun_v = 1;
  int                  sun_h = 1;

  dual_axis_light_tracker_stepper_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_right_bottom       (in_right_bottom),
    .in_left_bottom        (in_left_bottom),
    .in_right_top          (in_right_top),
    .in_left_top           (in_left_top),
    .in_knob               (in_knob),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_vertical_degrees  (out_vertical_degrees),
    .out_vertical_command  (out_vertical_command),
    .out_horizontal_degrees(out_horizontal_degrees),
    .out_horizontal_command(out_horizontal_command),
    .out_tolerance_now     (out_tolerance_now),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One quarter-degree move toward dir, clamped; the clamp is checked after the move.
  function automatic logic [QTR_BITS-1:0] nudge(input logic [QTR_BITS-1:0] q, input int dir,
                                                input logic [POS_BITS-1:0] lo,
                                                input logic [POS_BITS-1:0] hi);
    int nq;
    int qlo;
    int qhi;
    nq = q;
    qlo = lo;
    qhi = hi;
    qlo = qlo * 4;
    qhi = qhi * 4;
    nq = nq + dir;
    if (dir > 0 && nq > qhi) begin
      nq = qhi;
    end
    if (dir < 0 && nq < qlo) begin
      nq = qlo;
    end
    return nq[QTR_BITS-1:0];
  endfunction

  function automatic logic [POS_BITS-1:0] whole_deg(input logic [QTR_BITS-1:0] q);
    int r;
    r = q;
    r = (r + 2) >> 2;
    return r[POS_BITS-1:0];
  endfunction

  function automatic logic [SB-1:0] clip(input int v);
    if (v < 0) begin
      return '0;
    end
    if (v > 1023) begin
      return '1;
    end
    return v[SB-1:0];
  endfunction

  // Advances the tracker state by one request and returns the result it must produce.
  function automatic aim_t next_aim(input logic [SB-1:0] rb, input logic [SB-1:0] lb,
                                    input logic [SB-1:0] rt, input logic [SB-1:0] lt,
                                    input logic [SB-1:0] kn);
    int     top;
    int     bottom;
    int     left;
    int     right;
    int     dv;
    int     dh;
    int     tol_i;
    longint full;
    longint span;
    longint add;
    aim_t   a;
    top = (lt + rt) >> 1;
    bottom = (lb + rb) >> 1;
    left = (lb + lt) >> 1;
    right = (rb + rt) >> 1;
    dv = top - bottom;
    dh = left - right;
    tol_i = tol_cur;
    a.v_cmd = ((dv < 0) ? -dv : dv) > tol_i;
    a.h_cmd = ((dh < 0) ? -dh : dh) > tol_i;
    if (a.v_cmd) begin
      v_qtr = nudge(v_qtr, (top < bottom) ? 1 : -1, regs.vert_min, regs.vert_max);
    end
    if (a.h_cmd) begin
      h_qtr = nudge(h_qtr, (left < right) ? 1 : -1, regs.hor_min, regs.hor_max);
    end
    refresh_cnt = refresh_cnt + 1'b1;
    if (refresh_cnt >= regs.refresh_period) begin
      full = (1 << SB) - 1;
      span = (regs.tol_max >= regs.tol_min) ? regs.tol_max - regs.tol_min : 0;
      add = (2 * kn * span + full) / (2 * full);
      add = add + regs.tol_min;
      tol_cur = add[TOL_BITS-1:0];
      refresh_cnt = '0;
    end
    a.v_deg = whole_deg(v_qtr);
    a.h_deg = whole_deg(h_qtr);
    a.tol = tol_cur;
    return a;
  endfunction

  task automatic flag_fault(input string what, input int got, input int want);
    $display("tb_top: mismatch on %s: got %0d, expected %0d", what, got, want);
    fault_count++;
  endtask

  // Request monitor: predicts each accepted request and tracks cycles without progress.
  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (rst_n && in_valid && in_ready) begin
      aim_queue.push_back(next_aim(in_right_bottom, in_left_bottom, in_right_top,
                                   in_left_top, in_knob));
    end
  end

  always @(posedge clk) begin : check_results
    aim_t want;
    if (rst_n && out_valid && out_ready) begin
      if (aim_queue.size() == 0) begin
        flag_fault("result with no request pending", out_tolerance_now, 0);
      end else begin
        want = aim_queue.pop_front();
        if (out_vertical_degrees !== want.v_deg) begin
          flag_fault("vertical_degrees", out_vertical_degrees, want.v_deg);
        end
        if (out_vertical_command !== want.v_cmd) begin
          flag_fault("vertical_command", out_vertical_command, want.v_cmd);
        end
        if (out_horizontal_degrees !== want.h_deg) begin
          flag_fault("horizontal_degrees", out_horizontal_degrees, want.h_deg);
        end
        if (out_horizontal_command !== want.h_cmd) begin
          flag_fault("horizontal_command", out_horizontal_command, want.h_cmd);
        end
        if (out_tolerance_now !== want.tol) begin
          flag_fault("tolerance_now", out_tolerance_now, want.tol);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic send_samples(input logic [SB-1:0] rb, input logic [SB-1:0] lb,
                              input logic [SB-1:0] rt, input logic [SB-1:0] lt,
                              input logic [SB-1:0] kn);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_right_bottom <= rb;
    in_left_bottom <= lb;
    in_right_top <= rt;
    in_left_top <= lt;
    in_knob <= kn;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Holds off new requests until every pending result has been taken.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (aim_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_TOL_MIN:  regs.tol_min = val;
      REG_TOL_MAX:  regs.tol_max = val;
      REG_VERT_MIN: regs.vert_min = val[POS_BITS-1:0];
      REG_VERT_MAX: regs.vert_max = val[POS_BITS-1:0];
      REG_HOR_MIN:  regs.hor_min = val[POS_BITS-1:0];
      REG_HOR_MAX:  regs.hor_max = val[POS_BITS-1:0];
      REG_REFRESH:  regs.refresh_period = val[CNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [CFG_BITS-1:0] tmin, input logic [CFG_BITS-1:0] tmax,
                               input logic [CFG_BITS-1:0] vmin, input logic [CFG_BITS-1:0] vmax,
                               input logic [CFG_BITS-1:0] hmin, input logic [CFG_BITS-1:0] hmax,
                               input logic [CFG_BITS-1:0] period);
    drain();
    put_reg(REG_TOL_MIN, tmin);
    put_reg(REG_TOL_MAX, tmax);
    put_reg(REG_VERT_MIN, vmin);
    put_reg(REG_VERT_MAX, vmax);
    put_reg(REG_HOR_MIN, hmin);
    put_reg(REG_HOR_MAX, hmax);
    put_reg(REG_REFRESH, period);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_angle();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 180;
      default: return $urandom_range(0, 180);
    endcase
  endfunction

  task automatic random_settings();
    int tmin;
    int tmax;
    int vmin;
    int vmax;
    int hmin;
    int hmax;
    int period;
    case ($urandom_range(0, 5))
      0: tmin = 0;
      1: tmin = 1023;
      2, 3: tmin = $urandom_range(0, 150);
      default: tmin = $urandom_range(0, 1023);
    endcase
    case ($urandom_range(0, 5))
      0: tmax = 0;
      1: tmax = 1023;
      2, 3: tmax = $urandom_range(0, 300);
      default: tmax = $urandom_range(0, 1023);
    endcase
    vmin = pick_angle();
    vmax = ($urandom_range(0, 5) == 0) ? vmin : pick_angle();
    hmin = pick_angle();
    hmax = ($urandom_range(0, 5) == 0) ? hmin : pick_angle();
    case ($urandom_range(0, 5))
      0: period = 1;
      1: period = 255;
      2, 3, 4: period = $urandom_range(1, 8);
      default: period = $urandom_range(1, 255);
    endcase
    load_settings(tmin, tmax, vmin, vmax, hmin, hmax, period);
  endtask

  // Mostly a light source on one side with noise; else near tolerance, flat, extreme or noise.
  task automatic pick_samples(output logic [SB-1:0] rb, output logic [SB-1:0] lb,
                              output logic [SB-1:0] rt, output logic [SB-1:0] lt,
                              output logic [SB-1:0] kn);
    int base;
    int mv;
    int mh;
    int d;
    int hi_s;
    int lo_s;
    kn = $urandom_range(0, 1023);
    if ($urandom_range(0, 7) == 0) begin
      kn = $urandom_range(0, 1) ? '1 : '0;
    end
    case ($urandom_range(0, 9))
      0: begin
        rb = $urandom_range(0, 1023);
        lb = $urandom_range(0, 1023);
        rt = $urandom_range(0, 1023);
        lt = $urandom_range(0, 1023);
      end
      1: begin
        rb = $urandom_range(0, 1) ? '1 : '0;
        lb = $urandom_range(0, 1) ? '1 : '0;
        rt = $urandom_range(0, 1) ? '1 : '0;
        lt = $urandom_range(0, 1) ? '1 : '0;
      end
      8: begin
        d = tol_cur;
        d = d + int'($urandom_range(0, 2)) - 1;
        if (d < 0) begin
          d = 0;
        end
        if (d > 1023) begin
          d = 1023;
        end
        base = $urandom_range(0, 1023 - d);
        hi_s = base + d;
        lo_s = base;
        if ($urandom_range(0, 1)) begin
          hi_s = base;
          lo_s = base + d;
        end
        if ($urandom_range(0, 1)) begin
          lt = hi_s;
          rt = hi_s;
          lb = lo_s;
          rb = lo_s;
        end else begin
          lt = hi_s;
          lb = hi_s;
          rt = lo_s;
          rb = lo_s;
        end
      end
      9: begin
        base = $urandom_range(0, 1023);
        rb = base;
        lb = base;
        rt = base;
        lt = base;
      end
      default: begin
        base = $urandom_range(0, 700);
        mv = $urandom_range(0, 400);
        mh = $urandom_range(0, 400);
        mv = mv * sun_v;
        mh = mh * sun_h;
        lt = clip(base + mv + mh + int'($urandom_range(0, 40)) - 20);
        rt = clip(base + mv - mh + int'($urandom_range(0, 40)) - 20);
        lb = clip(base - mv + mh + int'($urandom_range(0, 40)) - 20);
        rb = clip(base - mv - mh + int'($urandom_range(0, 40)) - 20);
      end
    endcase
  endtask

  task automatic test_reset_defaults();
    send_samples(0, 0, 0, 0, 0);
    send_samples(1023, 1023, 1023, 1023, 1023);
    send_samples(512, 512, 512, 512, 512);
  endtask

  task automatic test_sample_extremes();
    send_samples(0, 0, 1023, 1023, 1023);
    send_samples(1023, 1023, 0, 0, 0);
    send_samples(0, 1023, 0, 1023, 512);
    send_samples(1023, 0, 1023, 0, 511);
    send_samples(0, 0, 0, 1023, 0);
  endtask

  // A difference equal to the tolerance must not move the axis; one above must.
  task automatic test_tolerance_edge();
    send_samples(200, 200, 300, 300, 0);
    send_samples(200, 200, 301, 301, 0);
    send_samples(200, 300, 200, 300, 0);
  endtask

  task automatic test_tolerance_reload();
    load_settings(0, 1023, 0, 50, 0, 100, 1);
    send_samples(100, 100, 100, 100, 0);
    send_samples(100, 100, 100, 100, 1023);
    send_samples(100, 100, 100, 100, 511);
    send_samples(100, 100, 100, 100, 512);
    // Reversed tolerance limits leave a span of zero; a period of zero reloads every request.
    load_settings(600, 200, 0, 50, 0, 100, 0);
    send_samples(100, 100, 100, 100, 1023);
    send_samples(100, 100, 100, 100, 700);
    load_settings(5, 9, 0, 180, 0, 180, 3);
    send_samples(100, 100, 100, 100, 1023);
    send_samples(100, 100, 100, 100, 1023);
    send_samples(100, 100, 100, 100, 1023);
  endtask

  // With reversed limits a step up lands on the upper limit and a step down on the lower one.
  task automatic test_clamp_limits();
    load_settings(0, 0, 100, 20, 180, 180, 1);
    send_samples(0, 0, 0, 0, 0);
    send_samples(1023, 1023, 0, 0, 0);
    send_samples(0, 0, 1023, 1023, 0);
    send_samples(0, 1023, 0, 1023, 0);
    load_settings(0, 0, 0, 0, 0, 0, 1);
    send_samples(1023, 0, 1023, 0, 0);
  endtask

  task automatic test_random_tracking(input int tx_pct, input int rx_pct, input int count);
    int            sent;
    int            block_len;
    logic [SB-1:0] rb;
    logic [SB-1:0] lb;
    logic [SB-1:0] rt;
    logic [SB-1:0] lt;
    logic [SB-1:0] kn;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < count) begin
      random_settings();
      sun_v = $urandom_range(0, 1) ? 1 : -1;
      sun_h = $urandom_range(0, 1) ? 1 : -1;
      block_len = $urandom_range(20, 60);
      for (int i = 0; i < block_len && sent < count; i++) begin
        if ($urandom_range(0, 24) == 0) begin
          sun_v = -sun_v;
        end
        if ($urandom_range(0, 24) == 0) begin
          sun_h = -sun_h;
        end
        if ($urandom_range(0, 79) == 0) begin
          drain();
        end
        pick_samples(rb, lb, rt, lt, kn);
        send_samples(rb, lb, rt, lt, kn);
        sent++;
      end
    end
  endtask

  initial begin
    regs = '{tol_min: TOL_MIN_RST, tol_max: TOL_MAX_RST, vert_min: VERT_MIN_RST,
             vert_max: VERT_MAX_RST, hor_min: HOR_MIN_RST, hor_max: HOR_MAX_RST,
             refresh_period: REFRESH_RST};
    v_qtr = QTR_RST;
    h_qtr = QTR_RST;
    tol_cur = TOL_RST;
    refresh_cnt = '0;
    tx_idle_pct = 24;
    rx_idle_pct = 58;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_sample_extremes();
    test_tolerance_edge();
    test_tolerance_reload();
    test_clamp_limits();
    test_random_tracking(24, 58, 235);
    test_random_tracking(58, 24, 235);
    test_random_tracking(0, 0, 235);
    drain();
    if (fault_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: dual_axis_light_tracker_stepper_unit.f
+incdir+sv
sv/dalt_pkg.sv
sv/dalt_cfg_regs.sv
sv/dalt_front.sv
sv/dalt_core.sv
sv/dual_axis_light_tracker_stepper_unit.sv
tb/tb_top.sv
